[src/i2cseq_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Shared types and constants for the I2C master byte sequencer.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned PhaseW      = 5;
  localparam int unsigned FuncW       = 3;

  // Queue between front and back
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  // Last phase of each command sequence
  localparam logic [PhaseW-1:0] LastStart = PhaseW'(4);
  localparam logic [PhaseW-1:0] LastWrite = PhaseW'(2 * BitsPerByte + 3);
  localparam logic [PhaseW-1:0] LastRead  = PhaseW'(2 * BitsPerByte);
  localparam logic [PhaseW-1:0] LastShort = PhaseW'(3);

  // Write ACK slot phases
  localparam logic [PhaseW-1:0] WrAckSetup  = PhaseW'(2 * BitsPerByte);
  localparam logic [PhaseW-1:0] WrAckSample = PhaseW'(2 * BitsPerByte + 1);
  localparam logic [PhaseW-1:0] WrAckEnd    = PhaseW'(2 * BitsPerByte + 2);

  // Phases of the short sequences
  localparam logic [PhaseW-1:0] Phase1 = PhaseW'(1);
  localparam logic [PhaseW-1:0] Phase2 = PhaseW'(2);
  localparam logic [PhaseW-1:0] Phase3 = PhaseW'(3);

  // Function codes; also the running operation (idle shares the tick code)
  typedef enum logic [FuncW-1:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_NACK  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    KIND_NOP  = 2'd0,
    KIND_TICK = 2'd1,
    KIND_CMD  = 2'd2
  } kind_e;

  // Classified item passed from front to back
  typedef struct packed {
    kind_e                  kind;
    op_e                    op;
    logic [BitsPerByte-1:0] wr_byte;
    logic                   sda;
  } item_t;

  // Result item
  typedef struct packed {
    logic                   rejected;
    logic                   ack_bit;
    logic [BitsPerByte-1:0] rx_byte;
    logic                   done_res;
    logic                   busy_res;
    logic                   sda_out;
    logic                   scl_out;
  } result_t;

  function automatic logic [PhaseW-1:0] last_phase(op_e op);
    logic [PhaseW-1:0] last;
    unique case (op)
      OP_START: last = LastStart;
      OP_WRITE: last = LastWrite;
      OP_READ:  last = LastRead;
      default:  last = LastShort;
    endcase
    return last;
  endfunction

endpackage

[src/i2cseq_front.sv]
// ----------------------------------------------------------------------------
// I2C sequencer front end
// Unpacks input items and classifies them as tick, command or no-op.
// ----------------------------------------------------------------------------
module i2cseq_front (
  input  logic [i2cseq_pkg::FuncW-1:0]       func_i,
  input  logic [i2cseq_pkg::BitsPerByte-1:0] write_byte_i,
  input  logic                               sda_in_i,
  output i2cseq_pkg::item_t                  item_o
);

  always_comb begin
    item_o.op      = i2cseq_pkg::op_e'(func_i);
    item_o.wr_byte = write_byte_i;
    item_o.sda     = sda_in_i;
    unique case (func_i)
      i2cseq_pkg::OP_IDLE: item_o.kind = i2cseq_pkg::KIND_TICK;
      i2cseq_pkg::OP_START, i2cseq_pkg::OP_STOP, i2cseq_pkg::OP_WRITE,
      i2cseq_pkg::OP_READ, i2cseq_pkg::OP_ACK, i2cseq_pkg::OP_NACK: begin
        item_o.kind = i2cseq_pkg::KIND_CMD;
      end
      // unused code: pass through without effect
      default: item_o.kind = i2cseq_pkg::KIND_NOP;
    endcase
  end

endmodule

[src/i2cseq_queue.sv]
// ----------------------------------------------------------------------------
// I2C sequencer item queue
// Short FIFO between the front end and the execution back end.
// ----------------------------------------------------------------------------
module i2cseq_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cseq_pkg::item_t push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output i2cseq_pkg::item_t pop_item_o,
  output logic              empty_o
);

  i2cseq_pkg::item_t                      mem_q [i2cseq_pkg::QueueDepth];
  logic [i2cseq_pkg::QueuePtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [i2cseq_pkg::QueuePtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [i2cseq_pkg::QueueCntW-1:0]       count_q, count_d;
  logic                                   do_push, do_pop;

  assign full_o     = (count_q == i2cseq_pkg::QueueCntW'(i2cseq_pkg::QueueDepth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == i2cseq_pkg::QueuePtrW'(i2cseq_pkg::QueueDepth - 1))
                 ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == i2cseq_pkg::QueuePtrW'(i2cseq_pkg::QueueDepth - 1))
                 ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[src/i2cseq_back.sv]
// ----------------------------------------------------------------------------
// I2C sequencer back end
// Runs the SCL/SDA phase sequence of each command and registers one result
// per item.
// ----------------------------------------------------------------------------
module i2cseq_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  i2cseq_pkg::item_t   item_i,
  output logic                item_pop_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output i2cseq_pkg::result_t res_o
);

  localparam int unsigned BW = i2cseq_pkg::BitsPerByte;
  localparam int unsigned PW = i2cseq_pkg::PhaseW;

  i2cseq_pkg::op_e     op_q, op_d;
  logic [PW-1:0]       phase_q, phase_d;
  logic [PW-1:0]       phase_inc;
  logic [BW-1:0]       shift_q, shift_d;
  logic                scl_q, scl_d;
  logic                sda_q, sda_d;
  logic                ack_q, ack_d;
  logic [BW-1:0]       rx_q, rx_d;
  logic                done, rej;
  logic                running, tick_run, cmd_start, is_last;
  logic                res_valid_q;
  i2cseq_pkg::result_t res_q;

  assign item_pop_o = item_valid_i && (!res_valid_q || res_ready_i);
  assign running    = (op_q != i2cseq_pkg::OP_IDLE);
  assign phase_inc  = phase_q + 1'b1;
  assign is_last    = (phase_inc >= i2cseq_pkg::last_phase(op_q));
  assign tick_run   = item_pop_o && (item_i.kind == i2cseq_pkg::KIND_TICK) && running;
  assign cmd_start  = item_pop_o && (item_i.kind == i2cseq_pkg::KIND_CMD) && !running;

  // Next operation and phase
  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    done    = 1'b0;
    rej     = item_pop_o && (item_i.kind == i2cseq_pkg::KIND_CMD) && running;
    if (tick_run) begin
      if (is_last) begin
        done    = 1'b1;
        op_d    = i2cseq_pkg::OP_IDLE;
        phase_d = '0;
      end else begin
        phase_d = phase_inc;
      end
    end else if (cmd_start) begin
      op_d    = item_i.op;
      phase_d = '0;
    end
  end

  // Pin levels and datapath
  always_comb begin
    shift_d = shift_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    ack_d   = ack_q;
    rx_d    = rx_q;
    if (cmd_start) begin
      unique case (item_i.op)
        i2cseq_pkg::OP_START: scl_d = 1'b1;
        i2cseq_pkg::OP_STOP:  sda_d = 1'b0;
        i2cseq_pkg::OP_WRITE: begin
          shift_d = item_i.wr_byte;
          sda_d   = item_i.wr_byte[BW-1];
        end
        i2cseq_pkg::OP_READ: begin
          shift_d = {{(BW-1){1'b0}}, item_i.sda};
          scl_d   = 1'b1;
        end
        i2cseq_pkg::OP_ACK:   sda_d = 1'b0;
        default:              sda_d = 1'b1;
      endcase
    end else if (tick_run) begin
      unique case (op_q)
        i2cseq_pkg::OP_START: begin
          if (phase_inc == i2cseq_pkg::Phase1) begin
            sda_d = 1'b1;
          end else if (phase_inc == i2cseq_pkg::Phase2) begin
            sda_d = 1'b0;
          end else if (phase_inc == i2cseq_pkg::Phase3) begin
            scl_d = 1'b0;
          end
        end
        i2cseq_pkg::OP_STOP: begin
          if (phase_inc == i2cseq_pkg::Phase1) begin
            scl_d = 1'b1;
          end else if (phase_inc == i2cseq_pkg::Phase2) begin
            sda_d = 1'b1;
          end
        end
        i2cseq_pkg::OP_WRITE: begin
          if (phase_inc < i2cseq_pkg::WrAckSetup) begin
            if (phase_inc[0]) begin
              scl_d = 1'b1;
            end else begin
              // shift out the next bit, MSB first
              scl_d   = 1'b0;
              shift_d = {shift_q[BW-2:0], 1'b0};
              sda_d   = shift_q[BW-2];
            end
          end else if (phase_inc == i2cseq_pkg::WrAckSetup) begin
            scl_d = 1'b0;
            sda_d = 1'b1;
          end else if (phase_inc == i2cseq_pkg::WrAckSample) begin
            scl_d = 1'b1;
            ack_d = item_i.sda;
          end else if (phase_inc == i2cseq_pkg::WrAckEnd) begin
            scl_d = 1'b0;
          end
        end
        i2cseq_pkg::OP_READ: begin
          if (phase_inc < i2cseq_pkg::LastRead) begin
            if (phase_inc[0]) begin
              scl_d = 1'b0;
            end else begin
              shift_d = {shift_q[BW-2:0], item_i.sda};
              scl_d   = 1'b1;
            end
          end else begin
            rx_d = shift_q;
          end
        end
        i2cseq_pkg::OP_ACK: begin
          if (phase_inc == i2cseq_pkg::Phase1) begin
            scl_d = 1'b1;
          end else if (phase_inc == i2cseq_pkg::Phase2) begin
            scl_d = 1'b0;
            sda_d = 1'b1;
          end
        end
        default: begin
          if (phase_inc == i2cseq_pkg::Phase1) begin
            scl_d = 1'b1;
          end else if (phase_inc == i2cseq_pkg::Phase2) begin
            scl_d = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= i2cseq_pkg::OP_IDLE;
      phase_q     <= '0;
      shift_q     <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_q       <= 1'b1;
      rx_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      op_q    <= op_d;
      phase_q <= phase_d;
      shift_q <= shift_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
      rx_q    <= rx_d;
      if (item_pop_o) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Result register: load on every item taken from the queue
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      res_q.scl_out  <= scl_d;
      res_q.sda_out  <= sda_d;
      res_q.busy_res <= (op_d != i2cseq_pkg::OP_IDLE);
      res_q.done_res <= done;
      res_q.rx_byte  <= rx_d;
      res_q.ack_bit  <= ack_d;
      res_q.rejected <= rej;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[src/i2c_master_byte_sequencer.sv]
// ----------------------------------------------------------------------------
// I2C master byte sequencer
// Steps an I2C master through start, stop, byte write, byte read and
// ACK/NACK sequences, one phase per tick item.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   write_byte[7:0], sda_in[8], zero [15:9]     func[2:0]
// m_axis   out  scl_out, sda_out, busy_res, done_res,       -
//               rx_byte[11:4], ack_bit[12], rejected[13], zero [15:14]
//
// One item per clock sustained; each item yields one result item (classify
// into the queue, then execute into the output register). The input stalls
// only once the receiver has held off long enough to fill the two-entry queue
// behind the output register.
// Reset (rst_ni low, asynchronous) idles the sequencer with both lines
// released, ack_bit 1 and rx_byte 0.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // write_byte[7:0], sda_in[8]
  input  logic [2:0]  s_axis_tuser_i,  // func[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // scl, sda, busy, done, rx[11:4], ack, rejected
);

  i2cseq_pkg::item_t   front_item;
  i2cseq_pkg::item_t   queue_item;
  i2cseq_pkg::result_t result;
  logic                queue_full, queue_empty, queue_pop;

  i2cseq_front u_front (
    .func_i       (s_axis_tuser_i),
    .write_byte_i (s_axis_tdata_i[7:0]),
    .sda_in_i     (s_axis_tdata_i[8]),
    .item_o       (front_item)
  );

  i2cseq_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_item_i (front_item),
    .full_o      (queue_full),
    .pop_i       (queue_pop),
    .pop_item_o  (queue_item),
    .empty_o     (queue_empty)
  );

  i2cseq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!queue_empty),
    .item_i       (queue_item),
    .item_pop_o   (queue_pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (result)
  );

  assign s_axis_tready_o = !queue_full;
  assign m_axis_tdata_o  = {2'b00, result};

endmodule
